[rtl/core/pbsd_pkg.sv]
`default_nettype none

package pbsd_pkg;

    localparam int TIME_W      = 32;
    localparam int CFG_W       = 16;
    localparam int CFG_ADDR_W  = 1;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 40;

    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE_TIME = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HOLD_TIME     = 1'd1;

    localparam logic [CFG_W-1:0] DEBOUNCE_TIME_RST = 16'd20;
    localparam logic [CFG_W-1:0] HOLD_TIME_RST     = 16'd2000;

    localparam logic OP_SAMPLE   = 1'b0;
    localparam logic OP_EVALUATE = 1'b1;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_time;
        logic [CFG_W-1:0] hold_time;
    } cfg_t;

    typedef struct packed {
        logic              pin_level;
        logic [TIME_W-1:0] now_ms;
    } in_word_t;

    typedef struct packed {
        logic [TIME_W-1:0] deadline_ms;
        logic              deadline_valid;
        logic              raw_changed;
        logic              shutdown_request;
    } res_t;

    typedef struct packed {
        logic              started;
        logic              raw_level;
        logic              stable_level;
        logic              armed;
        logic              holding;
        logic              fired;
        logic [TIME_W-1:0] raw_change_time;
        logic [TIME_W-1:0] hold_start_time;
    } state_t;

endpackage

`default_nettype wire

[rtl/core/pbsd_cfg.sv]
`default_nettype none

module pbsd_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [pbsd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [pbsd_pkg::CFG_W-1:0]      cfg_wdata,
    output pbsd_pkg::cfg_t                      cfg
);
    import pbsd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                REG_DEBOUNCE_TIME: cfg_next.debounce_time = cfg_wdata;
                REG_HOLD_TIME:     cfg_next.hold_time     = cfg_wdata;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_time <= DEBOUNCE_TIME_RST;
            cfg_reg.hold_time     <= HOLD_TIME_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[rtl/core/pbsd_core.sv]
`default_nettype none

module pbsd_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                fire,
    input  wire logic                op,
    input  wire pbsd_pkg::in_word_t  in_word,
    input  wire pbsd_pkg::cfg_t      cfg,
    output pbsd_pkg::res_t           res,
    output pbsd_pkg::state_t         st
);
    import pbsd_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] since_hold;
    logic              settle;
    logic              req;
    logic              changed;
    logic              dl_valid;
    logic [TIME_W-1:0] dl_base;
    logic [TIME_W-1:0] dl_off;
    logic [TIME_W-1:0] dl_raw;
    logic [TIME_W-1:0] dl_diff;

    assign now          = in_word.now_ms;
    assign since_change = now - state_reg.raw_change_time;
    assign since_hold   = now - state_reg.hold_start_time;
    assign settle       = (state_reg.stable_level != state_reg.raw_level)
                          && (since_change >= {16'd0, cfg.debounce_time});

    always_comb begin
        state_next = state_reg;
        req        = 1'b0;
        changed    = 1'b0;
        if (op == OP_SAMPLE) begin
            if (!state_reg.started) begin
                state_next.started         = 1'b1;
                state_next.raw_level       = in_word.pin_level;
                state_next.stable_level    = in_word.pin_level;
                state_next.armed           = !in_word.pin_level;
                state_next.raw_change_time = now;
            end else if (in_word.pin_level != state_reg.raw_level) begin
                state_next.raw_level       = in_word.pin_level;
                state_next.raw_change_time = now;
                changed                    = 1'b1;
            end
        end else if (state_reg.started) begin
            if (settle) begin
                state_next.stable_level = state_reg.raw_level;
            end
            if (!state_reg.armed) begin
                if (!state_next.stable_level) begin
                    state_next.armed = 1'b1;
                end
            end else if (!state_next.stable_level) begin
                state_next.holding         = 1'b0;
                state_next.fired           = 1'b0;
                state_next.hold_start_time = '0;
            end else if (!state_reg.holding) begin
                state_next.holding         = 1'b1;
                state_next.hold_start_time = now;
            end else if (!state_reg.fired && (since_hold >= {16'd0, cfg.hold_time})) begin
                state_next.fired = 1'b1;
                req              = 1'b1;
            end
        end
    end

    // next deadline from the updated state
    always_comb begin
        dl_valid = 1'b0;
        dl_base  = state_next.hold_start_time;
        dl_off   = {16'd0, cfg.hold_time};
        if (state_next.started) begin
            if (state_next.stable_level != state_next.raw_level) begin
                dl_valid = 1'b1;
                dl_base  = state_next.raw_change_time;
                dl_off   = {16'd0, cfg.debounce_time};
            end else if (state_next.armed && state_next.stable_level
                         && state_next.holding && !state_next.fired) begin
                dl_valid = 1'b1;
            end
        end
    end

    assign dl_raw  = dl_base + dl_off;
    assign dl_diff = dl_raw - now;

    always_comb begin
        res.shutdown_request = req;
        res.raw_changed      = changed;
        res.deadline_valid   = dl_valid;
        if (!dl_valid) begin
            res.deadline_ms = '0;
        end else if (dl_diff[TIME_W-1]) begin
            res.deadline_ms = now;
        end else begin
            res.deadline_ms = dl_raw;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    assign st = state_reg;

endmodule

`default_nettype wire

[rtl/core/power_button_long_press_shutdown_unit.sv]
`default_nettype none

// channel  dir  tuser       tdata (low bit up)
// s_       in   op          now_ms[31:0], pin_level, 7 zero bits
// m_       out  -           shutdown_request, raw_changed, deadline_valid,
//                           deadline_ms[31:0], 5 zero bits
// cfg_     in   -           index 0 debounce_time, index 1 hold_time
//
// one word per cycle sustained while m_tready is high; a word passes from s_ to m_
// through the input register and then the result register
// the state update and deadline are one pass of logic between those registers
// reset (aresetn low, synchronous) empties both registers and clears the state
// a stall on m_tready holds the result; the input register keeps filling
// until both registers are full

module power_button_long_press_shutdown_unit (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [pbsd_pkg::S_TDATA_W-1:0]   s_tdata,   // now_ms, pin_level
    input  wire logic                             s_tuser,   // op
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [pbsd_pkg::M_TDATA_W-1:0]        m_tdata,   // req, changed, dv, deadline
    input  wire logic                             cfg_we,
    input  wire logic [pbsd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [pbsd_pkg::CFG_W-1:0]       cfg_wdata
);
    import pbsd_pkg::*;

    cfg_t     cfg;
    res_t     res;
    state_t   st;
    logic     in_valid_reg;
    logic     in_valid_next;
    in_word_t in_word_reg;
    logic     in_op_reg;
    logic     out_valid_reg;
    logic     out_valid_next;
    res_t     out_res_reg;
    logic     advance;
    logic     s_fire;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    pbsd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pbsd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .op      (in_op_reg),
        .in_word (in_word_reg),
        .cfg     (cfg),
        .res     (res),
        .st      (st)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_word_reg <= s_tdata[TIME_W:0];
            in_op_reg   <= s_tuser;
        end
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - $bits(res_t)){1'b0}}, out_res_reg};

    a_fired_holding: assert property (@(posedge aclk) disable iff (!aresetn)
        st.fired |-> st.holding)
        else $error("fired without a running hold");

    a_holding_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        st.holding |-> st.armed)
        else $error("hold timer running while not armed");

    a_req_changed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(out_res_reg.shutdown_request && out_res_reg.raw_changed))
        else $error("request and wake in one word");

    a_no_deadline: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !out_res_reg.deadline_valid) |-> (out_res_reg.deadline_ms == '0))
        else $error("deadline set without a pending deadline");

endmodule

`default_nettype wire
